// ----- design/lsag_pkg.sv -----
package lsag_pkg;

  typedef enum logic [2:0] {
    MODE_BASE  = 3'd0,
    MODE_DISP  = 3'd1,
    MODE_LIT   = 3'd2,
    MODE_REG   = 3'd3,
    MODE_REGNS = 3'd4,
    MODE_PRF   = 3'd5,
    MODE_NYI   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_NYI  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    EXT_UXTB = 3'd0,
    EXT_UXTH = 3'd1,
    EXT_UXTW = 3'd2,
    EXT_UXTX = 3'd3,
    EXT_SXTB = 3'd4,
    EXT_SXTH = 3'd5,
    EXT_SXTW = 3'd6,
    EXT_SXTX = 3'd7
  } ext_e;

  localparam int unsigned AddrW   = 64;
  localparam int unsigned SizeW   = 5;
  localparam int unsigned DispW   = 21;
  localparam int unsigned ActionW = 5;

  typedef struct packed {
    mode_e            mode;
    logic [SizeW-1:0] size;
    logic             pair;
  } op_desc_t;

  // indexed by the dense operation code
  localparam op_desc_t OpTable [32] = '{
    '{MODE_BASE,  5'd4,  1'b0}, '{MODE_DISP,  5'd1,  1'b0}, '{MODE_DISP,  5'd1,  1'b0},
    '{MODE_REGNS, 5'd8,  1'b0}, '{MODE_BASE,  5'd2,  1'b0}, '{MODE_DISP,  5'd2,  1'b0},
    '{MODE_DISP,  5'd4,  1'b0}, '{MODE_LIT,   5'd8,  1'b0}, '{MODE_BASE,  5'd8,  1'b0},
    '{MODE_REG,   5'd8,  1'b0}, '{MODE_DISP,  5'd8,  1'b0}, '{MODE_DISP,  5'd16, 1'b1},
    '{MODE_DISP,  5'd8,  1'b1}, '{MODE_BASE,  5'd8,  1'b1}, '{MODE_DISP,  5'd4,  1'b0},
    '{MODE_DISP,  5'd8,  1'b0}, '{MODE_BASE,  5'd4,  1'b0}, '{MODE_PRF,   5'd0,  1'b0},
    '{MODE_BASE,  5'd4,  1'b0}, '{MODE_DISP,  5'd8,  1'b1}, '{MODE_DISP,  5'd8,  1'b1},
    '{MODE_DISP,  5'd16, 1'b1}, '{MODE_BASE,  5'd16, 1'b1}, '{MODE_DISP,  5'd2,  1'b0},
    '{MODE_DISP,  5'd16, 1'b0}, '{MODE_REG,   5'd4,  1'b0}, '{MODE_DISP,  5'd4,  1'b0},
    '{MODE_REG,   5'd8,  1'b0}, '{MODE_DISP,  5'd8,  1'b0}, '{MODE_DISP,  5'd4,  1'b0},
    '{MODE_BASE,  5'd4,  1'b0}, '{MODE_NYI,   5'd0,  1'b0}
  };

  // operands for the address adder
  typedef struct packed {
    logic [AddrW-1:0] opa;
    logic [AddrW-1:0] opb;
    logic [SizeW-1:0] size;
    status_e          status;
    logic             pair;
  } ops_t;

  // resolved access, addr2 is the second address of a pair
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] addr2;
    logic [SizeW-1:0] size;
    status_e          status;
    logic             pair;
  } acc_t;

  function automatic logic [AddrW-1:0] extend_index(logic [AddrW-1:0] idx, ext_e kind);
    logic [AddrW-1:0] e;
    case (kind)
      EXT_UXTB: e = {56'd0, idx[7:0]};
      EXT_UXTH: e = {48'd0, idx[15:0]};
      EXT_UXTW: e = {32'd0, idx[31:0]};
      EXT_SXTB: e = {{56{idx[7]}}, idx[7:0]};
      EXT_SXTH: e = {{48{idx[15]}}, idx[15:0]};
      EXT_SXTW: e = {{32{idx[31]}}, idx[31:0]};
      default:  e = idx;
    endcase
    return e;
  endfunction

endpackage

// ----- design/lsag_decode.sv -----
module lsag_decode (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [lsag_pkg::ActionW-1:0] action_i,
  input  logic [lsag_pkg::AddrW-1:0]   base_address_i,
  input  logic [lsag_pkg::AddrW-1:0]   index_value_i,
  input  logic [lsag_pkg::DispW-1:0]   displacement_i,
  input  logic [lsag_pkg::AddrW-1:0]   pc_value_i,
  input  logic [2:0]                   extend_kind_i,
  input  logic [2:0]                   shift_amount_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output lsag_pkg::ops_t               ops_o
);

  logic               valid_q;
  lsag_pkg::ops_t     ops_d, ops_q;

  always_comb begin
    lsag_pkg::op_desc_t         desc;
    logic [lsag_pkg::AddrW-1:0] ext;
    logic [lsag_pkg::AddrW-1:0] sdisp;
    desc  = lsag_pkg::OpTable[action_i];
    ext   = lsag_pkg::extend_index(index_value_i, lsag_pkg::ext_e'(extend_kind_i));
    sdisp = {{(lsag_pkg::AddrW - lsag_pkg::DispW){displacement_i[lsag_pkg::DispW-1]}},
             displacement_i};
    ops_d.opa    = '0;
    ops_d.opb    = '0;
    ops_d.size   = desc.size;
    ops_d.pair   = desc.pair;
    ops_d.status = lsag_pkg::ST_OK;
    unique case (desc.mode)
      lsag_pkg::MODE_BASE: ops_d.opa = base_address_i;
      lsag_pkg::MODE_DISP: begin
        ops_d.opa = base_address_i;
        ops_d.opb = sdisp;
      end
      lsag_pkg::MODE_LIT: begin
        ops_d.opa = pc_value_i;
        ops_d.opb = sdisp;
      end
      lsag_pkg::MODE_REG: begin
        ops_d.opa = base_address_i;
        ops_d.opb = ext << shift_amount_i;
      end
      lsag_pkg::MODE_REGNS: begin
        // shifted form of this load is not implemented
        if (shift_amount_i != 3'd0) begin
          ops_d.status = lsag_pkg::ST_NYI;
        end else begin
          ops_d.opa = base_address_i;
          ops_d.opb = ext;
        end
      end
      lsag_pkg::MODE_PRF: ops_d.status = lsag_pkg::ST_NONE;
      default:            ops_d.status = lsag_pkg::ST_NYI;
    endcase
    if (ops_d.status != lsag_pkg::ST_OK) begin
      ops_d.size = '0;
      ops_d.pair = 1'b0;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ops_q <= ops_d;
    end
  end

  assign valid_o = valid_q;
  assign ops_o   = ops_q;

endmodule

// ----- design/lsag_add.sv -----
module lsag_add (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  lsag_pkg::ops_t ops_i,
  output logic           valid_o,
  input  logic           ready_i,
  output lsag_pkg::acc_t acc_o
);

  // stage A: main address add; stage B: second address of a pair
  logic           a_valid_q, b_valid_q;
  logic           a_ready, b_ready;
  lsag_pkg::acc_t a_d, a_q, b_d, b_q;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;

  always_comb begin
    a_d.addr   = ops_i.opa + ops_i.opb;
    a_d.addr2  = '0;
    a_d.size   = ops_i.size;
    a_d.status = ops_i.status;
    a_d.pair   = ops_i.pair;
  end

  always_comb begin
    b_d       = a_q;
    b_d.addr2 = a_q.addr + {{(lsag_pkg::AddrW - lsag_pkg::SizeW){1'b0}}, a_q.size};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && a_ready) a_q <= a_d;
    if (a_valid_q && b_ready) b_q <= b_d;
  end

  assign valid_o = b_valid_q;
  assign acc_o   = b_q;

endmodule

// ----- design/lsag_out.sv -----
module lsag_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  lsag_pkg::acc_t             acc_i,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [lsag_pkg::AddrW-1:0] address_o,
  output logic [lsag_pkg::SizeW-1:0] access_size_o,
  output lsag_pkg::status_e          status_o,
  output logic                       last_o
);

  logic                       valid_q;
  logic                       last_q;
  logic [lsag_pkg::AddrW-1:0] addr_q, addr2_q;
  logic [lsag_pkg::SizeW-1:0] size_q;
  lsag_pkg::status_e          status_q;

  // a pair holds the stage for one extra beat
  assign ready_o = !valid_q || (m_ready_i && last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b1;
    end else if (ready_o) begin
      valid_q <= valid_i;
      if (valid_i) last_q <= !acc_i.pair;
    end else if (m_ready_i) begin
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      addr_q   <= acc_i.addr;
      addr2_q  <= acc_i.addr2;
      size_q   <= acc_i.size;
      status_q <= acc_i.status;
    end else if (valid_q && m_ready_i && !last_q) begin
      addr_q <= addr2_q;
    end
  end

  assign m_valid_o     = valid_q;
  assign address_o     = addr_q;
  assign access_size_o = size_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

  a_noacc_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && status_o != lsag_pkg::ST_OK |-> last_o && access_size_o == '0)
    else $error("no-access item not a single zero-size result");

  a_pair_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_ready_i && !last_o |=> m_valid_o && last_o &&
      access_size_o == $past(access_size_o) && status_o == lsag_pkg::ST_OK)
    else $error("second pair beat missing or malformed");

  a_pair_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && m_ready_i && !last_o |=> address_o == $past(address_o) +
      {{(lsag_pkg::AddrW - lsag_pkg::SizeW){1'b0}}, $past(access_size_o)})
    else $error("second pair address not first plus size");

endmodule

// ----- design/load_store_address_generator.sv -----
// Load/store address generator: one decoded memory operation in, its accesses out.
// An item enters every cycle unless the output side or a pair holds the flow; results pass
// through decode and index extend, address add, pair address add and the output register.
// A pair gives two results one after the other and holds the output register for the extra
// one; with the pipeline full the input side takes no item while a pair's first result is
// shown, so a pair holds back the input for its extra result. Prefetch and unsupported
// operations give one result with size 0 and the matching status.
module load_store_address_generator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // base_address[63:0], index_value[127:64], displacement[148:128], pc_value[212:149],
  // extend_kind[215:213], shift_amount[218:216], zero fill
  input  logic [223:0] s_axis_tdata_i,
  // action[4:0]
  input  logic [4:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // address[63:0], access_size[68:64], zero fill
  output logic [71:0]  m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);

  logic                       dec_valid, dec_ready;
  logic                       add_valid, add_ready;
  lsag_pkg::ops_t             dec_ops;
  lsag_pkg::acc_t             add_acc;
  logic [lsag_pkg::AddrW-1:0] address;
  logic [lsag_pkg::SizeW-1:0] access_size;
  lsag_pkg::status_e          status;

  lsag_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (s_axis_tvalid_i),
    .ready_o        (s_axis_tready_o),
    .action_i       (s_axis_tuser_i),
    .base_address_i (s_axis_tdata_i[63:0]),
    .index_value_i  (s_axis_tdata_i[127:64]),
    .displacement_i (s_axis_tdata_i[148:128]),
    .pc_value_i     (s_axis_tdata_i[212:149]),
    .extend_kind_i  (s_axis_tdata_i[215:213]),
    .shift_amount_i (s_axis_tdata_i[218:216]),
    .valid_o        (dec_valid),
    .ready_i        (dec_ready),
    .ops_o          (dec_ops)
  );

  lsag_add u_add (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .ops_i   (dec_ops),
    .valid_o (add_valid),
    .ready_i (add_ready),
    .acc_o   (add_acc)
  );

  lsag_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (add_valid),
    .ready_o       (add_ready),
    .acc_i         (add_acc),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .address_o     (address),
    .access_size_o (access_size),
    .status_o      (status),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, access_size, address};
  assign m_axis_tuser_o = status;

endmodule

// ----- tb/lsag_access_checker.sv -----
module lsag_access_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_tvalid_i,
  input  logic         op_tready_i,
  input  logic [223:0] op_tdata_i,
  input  logic [4:0]   op_tuser_i,
  input  logic         acc_tvalid_i,
  input  logic         acc_tready_i,
  input  logic [71:0]  acc_tdata_i,
  input  logic [1:0]   acc_tuser_i,
  input  logic         acc_tlast_i,
  output int unsigned  mismatches_o,
  output int unsigned  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    lsag_pkg::mode_e mode;
    logic [4:0]      size;
    logic            pair;
  } op_info_t;

  typedef struct packed {
    logic [63:0]       addr;
    logic [4:0]        size;
    lsag_pkg::status_e status;
    logic              last;
  } access_t;

  // address form, bytes per access and pair flag for every operation code
  localparam op_info_t OpCatalog [32] = '{
    '{lsag_pkg::MODE_BASE, 5'd4, 1'b0},   '{lsag_pkg::MODE_DISP, 5'd1, 1'b0},
    '{lsag_pkg::MODE_DISP, 5'd1, 1'b0},   '{lsag_pkg::MODE_REGNS, 5'd8, 1'b0},
    '{lsag_pkg::MODE_BASE, 5'd2, 1'b0},   '{lsag_pkg::MODE_DISP, 5'd2, 1'b0},
    '{lsag_pkg::MODE_DISP, 5'd4, 1'b0},   '{lsag_pkg::MODE_LIT, 5'd8, 1'b0},
    '{lsag_pkg::MODE_BASE, 5'd8, 1'b0},   '{lsag_pkg::MODE_REG, 5'd8, 1'b0},
    '{lsag_pkg::MODE_DISP, 5'd8, 1'b0},   '{lsag_pkg::MODE_DISP, 5'd16, 1'b1},
    '{lsag_pkg::MODE_DISP, 5'd8, 1'b1},   '{lsag_pkg::MODE_BASE, 5'd8, 1'b1},
    '{lsag_pkg::MODE_DISP, 5'd4, 1'b0},   '{lsag_pkg::MODE_DISP, 5'd8, 1'b0},
    '{lsag_pkg::MODE_BASE, 5'd4, 1'b0},   '{lsag_pkg::MODE_PRF, 5'd0, 1'b0},
    '{lsag_pkg::MODE_BASE, 5'd4, 1'b0},   '{lsag_pkg::MODE_DISP, 5'd8, 1'b1},
    '{lsag_pkg::MODE_DISP, 5'd8, 1'b1},   '{lsag_pkg::MODE_DISP, 5'd16, 1'b1},
    '{lsag_pkg::MODE_BASE, 5'd16, 1'b1},  '{lsag_pkg::MODE_DISP, 5'd2, 1'b0},
    '{lsag_pkg::MODE_DISP, 5'd16, 1'b0},  '{lsag_pkg::MODE_REG, 5'd4, 1'b0},
    '{lsag_pkg::MODE_DISP, 5'd4, 1'b0},   '{lsag_pkg::MODE_REG, 5'd8, 1'b0},
    '{lsag_pkg::MODE_DISP, 5'd8, 1'b0},   '{lsag_pkg::MODE_DISP, 5'd4, 1'b0},
    '{lsag_pkg::MODE_BASE, 5'd4, 1'b0},   '{lsag_pkg::MODE_NYI, 5'd0, 1'b0}
  };

  access_t pending_accesses [$];
  access_t oldest;

  function automatic logic [63:0] scaled_index(logic [63:0] idx, lsag_pkg::ext_e kind,
                                               logic [2:0] sh);
    logic [63:0] v;
    case (kind)
      lsag_pkg::EXT_UXTB: v = 64'(idx[7:0]);
      lsag_pkg::EXT_UXTH: v = 64'(idx[15:0]);
      lsag_pkg::EXT_UXTW: v = 64'(idx[31:0]);
      lsag_pkg::EXT_SXTB: v = 64'($signed(idx[7:0]));
      lsag_pkg::EXT_SXTH: v = 64'($signed(idx[15:0]));
      lsag_pkg::EXT_SXTW: v = 64'($signed(idx[31:0]));
      default:            v = idx;
    endcase
    // bits shifted past bit 63 are dropped
    return v << sh;
  endfunction

  function automatic void predict_accesses(logic [4:0] action, logic [223:0] data);
    op_info_t       op;
    logic [63:0]    base, idx, disp, pc, addr;
    lsag_pkg::ext_e kind;
    logic [2:0]     sh;
    op   = OpCatalog[action];
    base = data[63:0];
    idx  = data[127:64];
    disp = 64'($signed(data[148:128]));
    pc   = data[212:149];
    kind = lsag_pkg::ext_e'(data[215:213]);
    sh   = data[218:216];
    case (op.mode)
      lsag_pkg::MODE_BASE:  addr = base;
      lsag_pkg::MODE_DISP:  addr = base + disp;
      lsag_pkg::MODE_LIT:   addr = pc + disp;
      lsag_pkg::MODE_REG:   addr = base + scaled_index(idx, kind, sh);
      lsag_pkg::MODE_REGNS: addr = base + scaled_index(idx, kind, 3'd0);
      default:              addr = '0;
    endcase
    if (op.mode == lsag_pkg::MODE_PRF) begin
      pending_accesses.push_back(access_t'{64'd0, 5'd0, lsag_pkg::ST_NONE, 1'b1});
    end else if (op.mode == lsag_pkg::MODE_NYI ||
                 (op.mode == lsag_pkg::MODE_REGNS && sh != 3'd0)) begin
      pending_accesses.push_back(access_t'{64'd0, 5'd0, lsag_pkg::ST_NYI, 1'b1});
    end else begin
      pending_accesses.push_back(access_t'{addr, op.size, lsag_pkg::ST_OK, !op.pair});
      if (op.pair) begin
        pending_accesses.push_back(access_t'{addr + 64'(op.size), op.size,
                                             lsag_pkg::ST_OK, 1'b1});
      end
    end
  endfunction

  task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t: access mismatch on %s: expected %0h, got %0h", $time, field, want, got);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_accesses.delete();
      mismatches_o = 0;
      outstanding_o <= 0;
    end else begin
      if (op_tvalid_i && op_tready_i) begin
        predict_accesses(op_tuser_i, op_tdata_i);
      end
      if (acc_tvalid_i && acc_tready_i) begin
        if (pending_accesses.size() == 0) begin
          report_mismatch("unexpected item", 64'd0, acc_tdata_i[63:0]);
        end else begin
          oldest = pending_accesses.pop_front();
          if (acc_tdata_i[63:0] != oldest.addr) begin
            report_mismatch("address", oldest.addr, acc_tdata_i[63:0]);
          end
          if (acc_tdata_i[68:64] != oldest.size) begin
            report_mismatch("access_size", 64'(oldest.size), 64'(acc_tdata_i[68:64]));
          end
          if (acc_tuser_i != oldest.status) begin
            report_mismatch("status", 64'(oldest.status), 64'(acc_tuser_i));
          end
          if (acc_tlast_i != oldest.last) begin
            report_mismatch("last", 64'(oldest.last), 64'(acc_tlast_i));
          end
        end
      end
      outstanding_o <= pending_accesses.size();
    end
  end

endmodule

// ----- tb/tb_load_store_address_generator.sv -----
module tb_load_store_address_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] OP_LDR_D_ROX   = 5'd3;
  localparam logic [4:0] OP_LDR_X_LIT   = 5'd7;
  localparam logic [4:0] OP_LDR_X_ROX   = 5'd9;
  localparam logic [4:0] OP_STP_Q_POST  = 5'd22;
  localparam logic [4:0] OP_STR_X_ROX   = 5'd27;
  localparam logic [4:0] OP_UNSUPPORTED = 5'd31;
  localparam int unsigned NumActions    = 32;
  localparam int unsigned ItemsPerPhase = 400;
  localparam int unsigned QuietLimit    = 2000;

  logic         clk_i      = 1'b0;
  logic         rst_ni     = 1'b0;
  logic         op_tvalid  = 1'b0;
  logic         op_tready;
  logic [223:0] op_tdata   = '0;
  logic [4:0]   op_tuser   = '0;
  logic         acc_tvalid;
  logic         acc_tready = 1'b0;
  logic [71:0]  acc_tdata;
  logic [1:0]   acc_tuser;
  logic         acc_tlast;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned quiet_cycles  = 0;

  load_store_address_generator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (op_tvalid),
    .s_axis_tready_o (op_tready),
    .s_axis_tdata_i  (op_tdata),
    .s_axis_tuser_i  (op_tuser),
    .m_axis_tvalid_o (acc_tvalid),
    .m_axis_tready_i (acc_tready),
    .m_axis_tdata_o  (acc_tdata),
    .m_axis_tuser_o  (acc_tuser),
    .m_axis_tlast_o  (acc_tlast)
  );

  lsag_access_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_tvalid_i   (op_tvalid),
    .op_tready_i   (op_tready),
    .op_tdata_i    (op_tdata),
    .op_tuser_i    (op_tuser),
    .acc_tvalid_i  (acc_tvalid),
    .acc_tready_i  (acc_tready),
    .acc_tdata_i   (acc_tdata),
    .acc_tuser_i   (acc_tuser),
    .acc_tlast_i   (acc_tlast),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    acc_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (op_tvalid && op_tready) || (acc_tvalid && acc_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [223:0] pack_op(logic [63:0] base, logic [63:0] idx,
                                           logic [20:0] disp, logic [63:0] pc,
                                           lsag_pkg::ext_e kind, logic [2:0] sh);
    return {5'd0, sh, kind, pc, disp, idx, base};
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 64'd0;
      1:       return ~64'd0;
      2:       return ~64'd0 - 64'($urandom_range(0, 64));
      3:       return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [20:0] pick_disp();
    case ($urandom_range(0, 7))
      0:       return 21'h100000;
      1:       return 21'h0FFFFF;
      2:       return 21'($urandom_range(0, 255));
      3:       return ~21'($urandom_range(0, 255));
      default: return 21'($urandom);
    endcase
  endfunction

  task automatic send_op(logic [4:0] action, logic [223:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      op_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    op_tvalid <= 1'b1;
    op_tuser  <= action;
    op_tdata  <= data;
    @(posedge clk_i);
    while (!op_tready) @(posedge clk_i);
  endtask

  task automatic send_random_op();
    logic [4:0] action;
    logic [2:0] sh;
    action = 5'($urandom_range(0, OP_UNSUPPORTED));
    sh     = 3'($urandom_range(0, 7));
    // keep the unshifted double register load common enough
    if (action == OP_LDR_D_ROX && $urandom_range(0, 1)) sh = 3'd0;
    send_op(action, pack_op(pick_word(), pick_word(), pick_disp(), pick_word(),
                            lsag_pkg::ext_e'($urandom_range(0, 7)), sh));
  endtask

  // hold off the sender until every predicted access has come back
  task automatic wait_drained();
    op_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned a;
    logic [63:0] base;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every operation once, with extreme operands
    for (a = 0; a < NumActions; a++) begin
      base = (a % 3 == 0) ? ~64'd0 : (a % 3 == 1) ? 64'd0 : 64'h0000_7FFF_FFFF_FFF0;
      send_op(5'(a), pack_op(base,
                             a[2] ? ~64'd0 : 64'h8000_0000_8000_8080,
                             a[1] ? 21'h100000 : 21'h0FFFFF,
                             a[3] ? ~64'd0 : 64'h0000_0000_0040_0000,
                             lsag_pkg::ext_e'(a[2:0]), 3'(a % 8)));
    end
    send_op(OP_LDR_D_ROX, pack_op(64'h1000, 64'h8000_0000, 21'd0, 64'd0,
                                  lsag_pkg::EXT_SXTW, 3'd0));
    send_op(OP_LDR_D_ROX, pack_op(64'h1000, 64'h10, 21'd0, 64'd0,
                                  lsag_pkg::EXT_UXTX, 3'd4));
    send_op(OP_STR_X_ROX, pack_op(64'h20, ~64'd0, 21'd0, 64'd0,
                                  lsag_pkg::EXT_SXTX, 3'd7));
    send_op(OP_LDR_X_ROX, pack_op(64'd0, 64'h80, 21'd0, 64'd0,
                                  lsag_pkg::EXT_SXTB, 3'd0));
    send_op(OP_LDR_X_ROX, pack_op(64'd0, 64'h8000, 21'd0, 64'd0,
                                  lsag_pkg::EXT_SXTH, 3'd5));
    send_op(OP_STP_Q_POST, pack_op(~64'd0 - 64'd8, 64'd0, 21'd0, 64'd0,
                                   lsag_pkg::EXT_UXTB, 3'd0));
    send_op(OP_LDR_X_LIT, pack_op(64'd0, 64'd0, 21'h100000, 64'd0,
                                  lsag_pkg::EXT_UXTB, 3'd0));
    wait_drained();

    for (a = 0; a < 4; a++) begin
      case (a)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 86; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      repeat (ItemsPerPhase) send_random_op();
      wait_drained();
    end

    // catch any stray item behind the last expected one
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
